// ===== src/phase_current_preprocess_macros.svh =====
// assertion helpers used by phase_current_preprocess
// each one expects clk and rst_n in the enclosing module
`ifndef PHASE_CURRENT_PREPROCESS_MACROS_SVH
`define PHASE_CURRENT_PREPROCESS_MACROS_SVH

// same-cycle implication
`define PCP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcp check failed");

// next-cycle implication
`define PCP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcp check failed");

`endif

// ===== src/pcp_pkg.sv =====
package pcp_pkg;

    localparam int DUTY_W     = 17;
    localparam int DIST_W     = 17;
    localparam int MARGIN_W   = 16;
    localparam int LIMIT_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [DUTY_W-1:0] DUTY_ONE = 17'd65536;

    // dropped phase codes
    localparam logic [1:0] DROP_NONE = 2'd0;
    localparam logic [1:0] DROP_A    = 2'd1;
    localparam logic [1:0] DROP_B    = 2'd2;
    localparam logic [1:0] DROP_C    = 2'd3;

    typedef struct packed {
        logic                en_recon;
        logic [1:0]          forced_drop;
        logic                en_auto;
        logic                en_cm;
        logic [MARGIN_W-1:0] margin;
        logic [LIMIT_W-1:0]  limit;
    } cfg_t;

    // per-word side information carried down the pipe
    typedef struct packed {
        logic [1:0] drop;
        logic       ok;
        logic       bad_inc;
        logic       forced_inc;
        logic       auto_inc;
    } item_info_t;

endpackage

// ===== src/pcp_lane.sv =====
module pcp_lane #(
    parameter int CW = 16
) (
    input  logic signed [CW-1:0]                raw,
    input  logic [pcp_pkg::DUTY_W-1:0]          duty,
    input  logic [pcp_pkg::LIMIT_W-1:0]         limit,
    output logic [pcp_pkg::DIST_W-1:0]          rail_gap,
    output logic                                over
);
    import pcp_pkg::*;

    localparam int CMPW = ((CW > LIMIT_W) ? CW : LIMIT_W) + 1;

    logic [DIST_W-1:0]      hi;
    logic signed [CMPW-1:0] raw_x;
    logic signed [CMPW-1:0] lim_x;

    // distance to the upper rail, duties above 1.0 fold back; rail_gap is the nearer of it and zero
    assign hi = (duty <= DUTY_ONE) ? (DUTY_ONE - duty) : (duty - DUTY_ONE);
    assign rail_gap = (duty < hi) ? duty : hi;

    assign raw_x = CMPW'(raw);
    assign lim_x = signed'(CMPW'(limit));
    assign over  = (raw_x > lim_x) || (raw_x < -lim_x);

endmodule

// ===== src/pcp_merge.sv =====
module pcp_merge #(
    parameter int CW = 16
) (
    input  pcp_pkg::cfg_t                 cfg,
    input  logic                          present,
    input  logic                          pwm_ok,
    input  logic signed [CW-1:0]          raw_a,
    input  logic signed [CW-1:0]          raw_b,
    input  logic signed [CW-1:0]          raw_c,
    input  logic [pcp_pkg::DIST_W-1:0]    dist_a,
    input  logic [pcp_pkg::DIST_W-1:0]    dist_b,
    input  logic [pcp_pkg::DIST_W-1:0]    dist_c,
    input  logic                          over_any,
    output logic signed [CW+1:0]          ph_a,
    output logic signed [CW+1:0]          ph_b,
    output logic signed [CW+1:0]          ph_c,
    output logic signed [CW+1:0]          sum,
    output pcp_pkg::item_info_t           info
);
    import pcp_pkg::*;

    localparam int PW = CW + 2;

    logic [DIST_W-1:0]    best;
    logic [1:0]           pick;
    logic                 auto_hit;
    logic [1:0]           drop;
    logic signed [PW-1:0] xa;
    logic signed [PW-1:0] xb;
    logic signed [PW-1:0] xc;

    always_comb
    begin
        // nearest rail wins, ties go to the earlier phase
        best = dist_a;
        pick = DROP_A;
        if (dist_b < best)
        begin
            best = dist_b;
            pick = DROP_B;
        end
        if (dist_c < best)
        begin
            best = dist_c;
            pick = DROP_C;
        end
        auto_hit = cfg.en_auto && pwm_ok && (best <= DIST_W'(cfg.margin));

        drop = DROP_NONE;
        if (present && cfg.en_recon)
        begin
            if (cfg.forced_drop != DROP_NONE)
                drop = cfg.forced_drop;
            else if (auto_hit)
                drop = pick;
        end

        xa = present ? PW'(raw_a) : '0;
        xb = present ? PW'(raw_b) : '0;
        xc = present ? PW'(raw_c) : '0;
        ph_a = xa;
        ph_b = xb;
        ph_c = xc;
        case (drop)
            DROP_A:  ph_a = -(xb + xc);
            DROP_B:  ph_b = -(xa + xc);
            DROP_C:  ph_c = -(xa + xb);
            default:
            begin
            end
        endcase
        sum = ph_a + ph_b + ph_c;

        info.drop       = drop;
        info.ok         = present && !over_any;
        info.bad_inc    = !(present && !over_any);
        info.forced_inc = present && cfg.en_recon && (cfg.forced_drop != DROP_NONE);
        info.auto_inc   = present && cfg.en_recon && (cfg.forced_drop == DROP_NONE)
                          && auto_hit;
    end

endmodule

// ===== src/pcp_sat_lane.sv =====
module pcp_sat_lane #(
    parameter int CW = 16
) (
    input  logic signed [CW+1:0] ph,
    input  logic signed [CW:0]   cm,
    input  logic                 en_cm,
    output logic signed [CW-1:0] q
);
    localparam int DW = CW + 3;
    localparam logic signed [DW-1:0] HI = {{(DW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [DW-1:0] LO = {{(DW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    logic signed [DW-1:0] diff;

    assign diff = DW'(ph) - (en_cm ? DW'(cm) : DW'(0));

    always_comb
    begin
        if (diff > HI)
            q = HI[CW-1:0];
        else if (diff < LO)
            q = LO[CW-1:0];
        else
            q = diff[CW-1:0];
    end

endmodule

// ===== src/phase_current_preprocess.sv =====
// channel   dir  tdata (low bit up)                              tuser
// s_*       in   raw_phase_a/b/c, gate_enabled, duty_a/b/c, pad   sample_present, pwm_known
// m_*       out  out_phase_a/b/c, dropped_phase, common_mode,     sample_ok
//                bad/forced/auto/drop_a/drop_b/drop_c totals, pad
// cfg_*     in   write enable, register index, write data         -
//
// one word per clock while the m side takes them, five register stages,
// so m_tvalid rises once a word accepted on the s side reaches the output
// register; the divide-by-three is done as a reciprocal multiply
// split into two partial products with a register after them
// rst_n clears the config registers to their defaults, all totals and the
// stage valids; a stalled m side backs the pipe up stage by stage
module phase_current_preprocess #(
    parameter int CURRENT_WIDTH = 16,
    parameter int COUNT_WIDTH   = 32,
    localparam int IN_USED  = 3 * CURRENT_WIDTH + 1 + 3 * pcp_pkg::DUTY_W,
    localparam int IN_DW    = ((IN_USED + 7) / 8) * 8,
    localparam int OUT_USED = 4 * CURRENT_WIDTH + 3 + 6 * COUNT_WIDTH,
    localparam int OUT_DW   = ((OUT_USED + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // raw_phase_a, raw_phase_b, raw_phase_c, gate_enabled, duty_a, duty_b, duty_c
    input  logic [IN_DW-1:0]                  s_tdata,
    // sample_present, pwm_known
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_phase_a, out_phase_b, out_phase_c, dropped_phase, common_mode,
    // bad_sample_total, forced_drop_total, auto_drop_total,
    // drop_a_total, drop_b_total, drop_c_total
    output logic [OUT_DW-1:0]                 m_tdata,
    // sample_ok
    output logic [0:0]                        m_tuser,
    input  logic                              cfg_we,
    input  logic [pcp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pcp_pkg::*;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_EN_RECON    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORCED_DROP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EN_AUTO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EN_CM       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT       = 3'd5;

    localparam logic [MARGIN_W-1:0] MARGIN_RST = 16'd3277;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 15'd20000;

    localparam int CW  = CURRENT_WIDTH;
    localparam int PW  = CW + 2;         // phase after rebuild
    localparam int SW  = CW + 2;         // phase sum
    localparam int NW  = CW + 1;         // |sum| + 1
    localparam int HW  = NW / 2;         // low split of the multiplier operand
    localparam int LW  = NW - HW;
    localparam int KW  = NW + 2;         // reciprocal precision
    localparam int PRW = NW + KW;
    localparam int CMW = CW + 1;

    localparam logic [KW-1:0] RECIP = KW'(((64'd1 << KW) + 64'd2) / 64'd3);

    // tdata field offsets
    localparam int OFF_B    = CW;
    localparam int OFF_C    = 2 * CW;
    localparam int OFF_GATE = 3 * CW;
    localparam int OFF_DA   = 3 * CW + 1;
    localparam int OFF_DB   = OFF_DA + DUTY_W;
    localparam int OFF_DC   = OFF_DB + DUTY_W;

    // configuration registers
    logic                en_recon_reg;
    logic [1:0]          forced_drop_reg;
    logic                en_auto_reg;
    logic                en_cm_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    cfg_t                cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_recon_reg    <= 1'b1;
            forced_drop_reg <= DROP_NONE;
            en_auto_reg     <= 1'b1;
            en_cm_reg       <= 1'b1;
            margin_reg      <= MARGIN_RST;
            limit_reg       <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EN_RECON:    en_recon_reg    <= cfg_data[0];
                REG_FORCED_DROP: forced_drop_reg <= cfg_data[1:0];
                REG_EN_AUTO:     en_auto_reg     <= cfg_data[0];
                REG_EN_CM:       en_cm_reg       <= cfg_data[0];
                REG_MARGIN:      margin_reg      <= cfg_data[MARGIN_W-1:0];
                REG_LIMIT:       limit_reg       <= cfg_data[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.en_recon    = en_recon_reg;
    assign cfg.forced_drop = forced_drop_reg;
    assign cfg.en_auto     = en_auto_reg;
    assign cfg.en_cm       = en_cm_reg;
    assign cfg.margin      = margin_reg;
    assign cfg.limit       = limit_reg;

    // pipeline handshake: each stage takes a word when empty or draining
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic out_valid_reg;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;
    logic rdy5;
    logic load1;
    logic load2;
    logic load3;
    logic load4;
    logic load5;

    assign rdy5  = !out_valid_reg || m_tready;
    assign rdy4  = !s4_valid_reg || rdy5;
    assign rdy3  = !s3_valid_reg || rdy4;
    assign rdy2  = !s2_valid_reg || rdy3;
    assign rdy1  = !s1_valid_reg || rdy2;
    assign load1 = s_tvalid && rdy1;
    assign load2 = s1_valid_reg && rdy2;
    assign load3 = s2_valid_reg && rdy3;
    assign load4 = s3_valid_reg && rdy4;
    assign load5 = s4_valid_reg && rdy5;

    assign s_tready = rdy1;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_valid_reg <= s_tvalid;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
            if (rdy4)
                s4_valid_reg <= s3_valid_reg;
            if (rdy5)
                out_valid_reg <= s4_valid_reg;
        end
    end

    // input unpacking
    logic signed [CW-1:0] in_raw_a;
    logic signed [CW-1:0] in_raw_b;
    logic signed [CW-1:0] in_raw_c;
    logic [DUTY_W-1:0]    in_duty_a;
    logic [DUTY_W-1:0]    in_duty_b;
    logic [DUTY_W-1:0]    in_duty_c;

    assign in_raw_a  = s_tdata[0 +: CW];
    assign in_raw_b  = s_tdata[OFF_B +: CW];
    assign in_raw_c  = s_tdata[OFF_C +: CW];
    assign in_duty_a = s_tdata[OFF_DA +: DUTY_W];
    assign in_duty_b = s_tdata[OFF_DB +: DUTY_W];
    assign in_duty_c = s_tdata[OFF_DC +: DUTY_W];

    // stage 1: one lane per phase, rail distance and limit check
    logic [DIST_W-1:0] dist_a;
    logic [DIST_W-1:0] dist_b;
    logic [DIST_W-1:0] dist_c;
    logic              over_a;
    logic              over_b;
    logic              over_c;

    pcp_lane #(.CW(CW)) u_lane_a (
        .raw      (in_raw_a),
        .duty     (in_duty_a),
        .limit    (cfg.limit),
        .rail_gap (dist_a),
        .over     (over_a)
    );

    pcp_lane #(.CW(CW)) u_lane_b (
        .raw      (in_raw_b),
        .duty     (in_duty_b),
        .limit    (cfg.limit),
        .rail_gap (dist_b),
        .over     (over_b)
    );

    pcp_lane #(.CW(CW)) u_lane_c (
        .raw      (in_raw_c),
        .duty     (in_duty_c),
        .limit    (cfg.limit),
        .rail_gap (dist_c),
        .over     (over_c)
    );

    logic signed [CW-1:0] s1_raw_a_reg;
    logic signed [CW-1:0] s1_raw_b_reg;
    logic signed [CW-1:0] s1_raw_c_reg;
    logic [DIST_W-1:0]    s1_dist_a_reg;
    logic [DIST_W-1:0]    s1_dist_b_reg;
    logic [DIST_W-1:0]    s1_dist_c_reg;
    logic                 s1_over_reg;
    logic                 s1_present_reg;
    logic                 s1_pwm_ok_reg;

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            s1_raw_a_reg   <= in_raw_a;
            s1_raw_b_reg   <= in_raw_b;
            s1_raw_c_reg   <= in_raw_c;
            s1_dist_a_reg  <= dist_a;
            s1_dist_b_reg  <= dist_b;
            s1_dist_c_reg  <= dist_c;
            s1_over_reg    <= over_a || over_b || over_c;
            s1_present_reg <= s_tuser[0];
            // no auto drop without a known, gated previous command
            s1_pwm_ok_reg  <= s_tuser[1] && s_tdata[OFF_GATE];
        end
    end

    // stage 2: merge the lanes, pick the dropped phase and rebuild it
    logic signed [PW-1:0] mg_ph_a;
    logic signed [PW-1:0] mg_ph_b;
    logic signed [PW-1:0] mg_ph_c;
    logic signed [SW-1:0] mg_sum;
    item_info_t           mg_info;

    pcp_merge #(.CW(CW)) u_merge (
        .cfg      (cfg),
        .present  (s1_present_reg),
        .pwm_ok   (s1_pwm_ok_reg),
        .raw_a    (s1_raw_a_reg),
        .raw_b    (s1_raw_b_reg),
        .raw_c    (s1_raw_c_reg),
        .dist_a   (s1_dist_a_reg),
        .dist_b   (s1_dist_b_reg),
        .dist_c   (s1_dist_c_reg),
        .over_any (s1_over_reg),
        .ph_a     (mg_ph_a),
        .ph_b     (mg_ph_b),
        .ph_c     (mg_ph_c),
        .sum      (mg_sum),
        .info     (mg_info)
    );

    logic signed [PW-1:0] s2_ph_a_reg;
    logic signed [PW-1:0] s2_ph_b_reg;
    logic signed [PW-1:0] s2_ph_c_reg;
    logic signed [SW-1:0] s2_sum_reg;
    item_info_t           s2_info_reg;

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            s2_ph_a_reg <= mg_ph_a;
            s2_ph_b_reg <= mg_ph_b;
            s2_ph_c_reg <= mg_ph_c;
            s2_sum_reg  <= mg_sum;
            s2_info_reg <= mg_info;
        end
    end

    // stage 3: round(sum / 3) = sign * floor((|sum| + 1) / 3),
    // floor(n / 3) by reciprocal multiply, operand split into a low and a high part
    logic [SW-1:0]    sum_mag;
    logic [NW-1:0]    div_n;
    logic [HW+KW-1:0] pp_lo;
    logic [LW+KW-1:0] pp_hi;

    assign sum_mag = s2_sum_reg[SW-1] ? SW'(-s2_sum_reg) : SW'(s2_sum_reg);
    assign div_n   = sum_mag[NW-1:0] + NW'(1);
    assign pp_lo   = {{KW{1'b0}}, div_n[HW-1:0]} * {{HW{1'b0}}, RECIP};
    assign pp_hi   = {{KW{1'b0}}, div_n[NW-1:HW]} * {{LW{1'b0}}, RECIP};

    logic signed [PW-1:0] s3_ph_a_reg;
    logic signed [PW-1:0] s3_ph_b_reg;
    logic signed [PW-1:0] s3_ph_c_reg;
    logic [HW+KW-1:0]     s3_pp_lo_reg;
    logic [LW+KW-1:0]     s3_pp_hi_reg;
    logic                 s3_neg_reg;
    item_info_t           s3_info_reg;

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            s3_ph_a_reg  <= s2_ph_a_reg;
            s3_ph_b_reg  <= s2_ph_b_reg;
            s3_ph_c_reg  <= s2_ph_c_reg;
            s3_pp_lo_reg <= pp_lo;
            s3_pp_hi_reg <= pp_hi;
            s3_neg_reg   <= s2_sum_reg[SW-1];
            s3_info_reg  <= s2_info_reg;
        end
    end

    // stage 4: add the partial products and restore the sign
    logic [PRW-1:0]        prod;
    logic [NW-1:0]         quot;
    logic signed [CMW-1:0] cm;

    assign prod = (PRW'(s3_pp_hi_reg) << HW) + PRW'(s3_pp_lo_reg);
    assign quot = prod[PRW-1:KW];
    assign cm   = s3_neg_reg ? -signed'(CMW'(quot)) : signed'(CMW'(quot));

    logic signed [PW-1:0]  s4_ph_a_reg;
    logic signed [PW-1:0]  s4_ph_b_reg;
    logic signed [PW-1:0]  s4_ph_c_reg;
    logic signed [CMW-1:0] s4_cm_reg;
    item_info_t            s4_info_reg;

    always_ff @(posedge clk)
    begin
        if (load4)
        begin
            s4_ph_a_reg <= s3_ph_a_reg;
            s4_ph_b_reg <= s3_ph_b_reg;
            s4_ph_c_reg <= s3_ph_c_reg;
            s4_cm_reg   <= cm;
            s4_info_reg <= s3_info_reg;
        end
    end

    // stage 5: remove common mode when enabled and saturate, one lane per phase
    logic signed [CW-1:0] sat_a;
    logic signed [CW-1:0] sat_b;
    logic signed [CW-1:0] sat_c;

    pcp_sat_lane #(.CW(CW)) u_sat_a (
        .ph    (s4_ph_a_reg),
        .cm    (s4_cm_reg),
        .en_cm (cfg.en_cm),
        .q     (sat_a)
    );

    pcp_sat_lane #(.CW(CW)) u_sat_b (
        .ph    (s4_ph_b_reg),
        .cm    (s4_cm_reg),
        .en_cm (cfg.en_cm),
        .q     (sat_b)
    );

    pcp_sat_lane #(.CW(CW)) u_sat_c (
        .ph    (s4_ph_c_reg),
        .cm    (s4_cm_reg),
        .en_cm (cfg.en_cm),
        .q     (sat_c)
    );

    // output register; the totals live here and step as each word lands
    logic signed [CW-1:0]  out_a_reg;
    logic signed [CW-1:0]  out_b_reg;
    logic signed [CW-1:0]  out_c_reg;
    logic [1:0]            out_drop_reg;
    logic                  out_ok_reg;
    logic signed [CMW-1:0] out_cm_reg;
    logic [COUNT_WIDTH-1:0] bad_cnt_reg;
    logic [COUNT_WIDTH-1:0] forced_cnt_reg;
    logic [COUNT_WIDTH-1:0] auto_cnt_reg;
    logic [COUNT_WIDTH-1:0] drop_a_cnt_reg;
    logic [COUNT_WIDTH-1:0] drop_b_cnt_reg;
    logic [COUNT_WIDTH-1:0] drop_c_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (load5)
        begin
            out_a_reg    <= sat_a;
            out_b_reg    <= sat_b;
            out_c_reg    <= sat_c;
            out_drop_reg <= s4_info_reg.drop;
            out_ok_reg   <= s4_info_reg.ok;
            out_cm_reg   <= s4_cm_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_cnt_reg    <= '0;
            forced_cnt_reg <= '0;
            auto_cnt_reg   <= '0;
            drop_a_cnt_reg <= '0;
            drop_b_cnt_reg <= '0;
            drop_c_cnt_reg <= '0;
        end
        else if (load5)
        begin
            if (s4_info_reg.bad_inc)
                bad_cnt_reg <= bad_cnt_reg + COUNT_WIDTH'(1);
            if (s4_info_reg.forced_inc)
                forced_cnt_reg <= forced_cnt_reg + COUNT_WIDTH'(1);
            if (s4_info_reg.auto_inc)
                auto_cnt_reg <= auto_cnt_reg + COUNT_WIDTH'(1);
            if (s4_info_reg.drop == DROP_A)
                drop_a_cnt_reg <= drop_a_cnt_reg + COUNT_WIDTH'(1);
            if (s4_info_reg.drop == DROP_B)
                drop_b_cnt_reg <= drop_b_cnt_reg + COUNT_WIDTH'(1);
            if (s4_info_reg.drop == DROP_C)
                drop_c_cnt_reg <= drop_c_cnt_reg + COUNT_WIDTH'(1);
        end
    end

    assign m_tdata = OUT_DW'({drop_c_cnt_reg, drop_b_cnt_reg, drop_a_cnt_reg,
                              auto_cnt_reg, forced_cnt_reg, bad_cnt_reg,
                              out_cm_reg, out_drop_reg,
                              out_c_reg, out_b_reg, out_a_reg});
    assign m_tuser = out_ok_reg;

    // checks
    `include "phase_current_preprocess_macros.svh"

    // a rebuilt phase makes the sum exactly zero
    `PCP_ASSERT_SAME(a_rebuilt_cm_zero, out_valid_reg && (out_drop_reg != DROP_NONE), out_cm_reg == '0)
    // totals only move when a word enters the output register
    `PCP_ASSERT_NEXT(a_totals_hold, !load5, $stable(bad_cnt_reg) && $stable(forced_cnt_reg) && $stable(auto_cnt_reg))
    // an auto drop never coincides with a forced one and always names a phase
    `PCP_ASSERT_SAME(a_auto_excl, s4_valid_reg && s4_info_reg.auto_inc, !s4_info_reg.forced_inc && (s4_info_reg.drop != DROP_NONE))

endmodule
